FILE: rtl/most_vital_edge_shortest_path_macros.svh
// assertion macros for the most vital edge shortest path block
`ifndef MOST_VITAL_EDGE_SHORTEST_PATH_MACROS_SVH
`define MOST_VITAL_EDGE_SHORTEST_PATH_MACROS_SVH
`ifndef ASSERT_OFF
// property that holds at every clock edge out of reset
`define MVESP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on the same edge
`define MVESP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MVESP_ASSERT(lbl, prop, msg)
`define MVESP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/mvesp_pkg.sv
// shared types and constants of the most vital edge shortest path block
package mvesp_pkg;

    localparam int NODE_BITS   = 7;
    localparam int WIN_BITS    = 16;
    localparam int OUT_BITS    = 22;
    localparam int COUNT_BITS  = 7;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 48;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

    // block level sequencer
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_BASE,
        ST_WALK_RD,
        ST_WALK_WAIT,
        ST_BLOCK_WAIT,
        ST_EMIT
    } top_state_t;

    // search engine sequencer
    typedef enum logic [2:0] {
        SS_IDLE,
        SS_INIT,
        SS_POP,
        SS_POPW,
        SS_DU,
        SS_SCAN,
        SS_DONE
    } srch_state_t;

    typedef struct packed {
        logic start;
        logic record;
        logic blocking;
    } search_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic reached;
    } search_status_t;

endpackage

FILE: rtl/mvesp_edge_ram.sv
// edge weight memory, one write port and one registered read port
module mvesp_edge_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 17
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);
    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/mvesp_search.sv
// fifo label-correcting search over the edge memory
module mvesp_search #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16,
    parameter int IDX_BITS     = 6,
    parameter int DIST_BITS    = 22
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mvesp_pkg::search_cmd_t     cmd,
    input  logic [IDX_BITS-1:0]        block_a,
    input  logic [IDX_BITS-1:0]        block_b,
    input  logic [IDX_BITS-1:0]        last_idx,
    output mvesp_pkg::search_status_t  status,
    output logic [DIST_BITS-1:0]       target_dist,
    output logic [2*IDX_BITS-1:0]      edge_raddr,
    input  logic [WEIGHT_BITS:0]       edge_rdata,
    input  logic [IDX_BITS-1:0]        path_addr,
    output logic [IDX_BITS-1:0]        path_data
);
    import mvesp_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
    localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(MAX_VERTICES - 1);

    srch_state_t state_reg, state_next;
    logic [MAX_VERTICES-1:0] valid_reg, valid_next;
    logic [MAX_VERTICES-1:0] mark_reg, mark_next;
    logic [IDX_BITS-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [IDX_BITS-1:0] u_reg, u_next, j_reg, j_next;
    logic [IDX_BITS-1:0] ba_reg, ba_next, bb_reg, bb_next;
    logic record_reg, record_next, blocking_reg, blocking_next;
    logic [DIST_BITS-1:0] du_reg, du_next;

    logic [DIST_BITS-1:0] dist_mem [MAX_VERTICES];
    logic [IDX_BITS-1:0]  queue_mem [MAX_VERTICES];
    logic [IDX_BITS-1:0]  path_mem [MAX_VERTICES];

    logic [IDX_BITS-1:0]  dist_raddr, dist_waddr, q_raddr, q_waddr, path_waddr, path_wdata;
    logic [DIST_BITS-1:0] dist_rdata, dist_wdata;
    logic [IDX_BITS-1:0]  q_rdata, q_wdata;
    logic dist_we, q_we, path_we;

    logic [IDX_BITS-1:0]  rd_idx;
    logic [DIST_BITS-1:0] nd;
    logic present, blocked, relax;

    // scan evaluation of the vertex whose data is on the read ports
    assign present = edge_rdata[WEIGHT_BITS];
    assign nd      = du_reg + DIST_BITS'(edge_rdata[WEIGHT_BITS-1:0]);
    assign blocked = blocking_reg && (((u_reg == ba_reg) && (j_reg == bb_reg))
                                   || ((u_reg == bb_reg) && (j_reg == ba_reg)));
    assign relax   = present && !blocked && (!valid_reg[j_reg] || (nd < dist_rdata));

    // vertex whose neighbor data is fetched this cycle
    assign rd_idx = (state_reg == SS_DU) ? '0 : IDX_BITS'(j_reg + 1'b1);
    assign edge_raddr = (u_reg < rd_idx) ? {u_reg, rd_idx} : {rd_idx, u_reg};

    assign status.busy    = (state_reg != SS_IDLE);
    assign status.done    = (state_reg == SS_DONE);
    assign status.reached = valid_reg[last_idx];
    assign target_dist    = dist_rdata;

    // memories; reads and writes of one entry never meet in one cycle
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rdata <= dist_mem[dist_raddr];
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        q_rdata <= queue_mem[q_raddr];
        if (path_we)
        begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_data <= path_mem[path_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SS_IDLE;
            valid_reg <= '0;
            mark_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        j_reg        <= j_next;
        ba_reg       <= ba_next;
        bb_reg       <= bb_next;
        record_reg   <= record_next;
        blocking_reg <= blocking_next;
        du_reg       <= du_next;
    end

    // next state and memory controls
    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        mark_next     = mark_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        u_next        = u_reg;
        j_next        = j_reg;
        ba_next       = ba_reg;
        bb_next       = bb_reg;
        record_next   = record_reg;
        blocking_next = blocking_reg;
        du_next       = du_reg;
        dist_raddr    = rd_idx;
        dist_we       = 1'b0;
        dist_waddr    = j_reg;
        dist_wdata    = nd;
        q_raddr       = head_reg;
        q_we          = 1'b0;
        q_waddr       = tail_reg;
        q_wdata       = j_reg;
        path_we       = 1'b0;
        path_waddr    = j_reg;
        path_wdata    = u_reg;
        case (state_reg)
            SS_IDLE:
            begin
                if (cmd.start)
                begin
                    record_next   = cmd.record;
                    blocking_next = cmd.blocking;
                    ba_next       = block_a;
                    bb_next       = block_b;
                    state_next    = SS_INIT;
                end
            end
            SS_INIT:
            begin
                // source gets distance zero and sits alone in the queue
                valid_next    = '0;
                valid_next[0] = 1'b1;
                mark_next     = '0;
                mark_next[0]  = 1'b1;
                dist_we       = 1'b1;
                dist_waddr    = '0;
                dist_wdata    = '0;
                q_we          = 1'b1;
                q_waddr       = '0;
                q_wdata       = '0;
                head_next     = '0;
                tail_next     = IDX_BITS'(1 % MAX_VERTICES);
                count_next    = CNT_BITS'(1);
                state_next    = SS_POP;
            end
            SS_POP:
            begin
                if (count_reg == '0)
                begin
                    dist_raddr = last_idx;
                    state_next = SS_DONE;
                end
                else
                begin
                    head_next  = (head_reg == LAST_SLOT) ? '0 : IDX_BITS'(head_reg + 1'b1);
                    count_next = CNT_BITS'(count_reg - 1'b1);
                    state_next = SS_POPW;
                end
            end
            SS_POPW:
            begin
                u_next           = q_rdata;
                mark_next[q_rdata] = 1'b0;
                dist_raddr       = q_rdata;
                state_next       = SS_DU;
            end
            SS_DU:
            begin
                du_next    = dist_rdata;
                j_next     = '0;
                state_next = SS_SCAN;
            end
            SS_SCAN:
            begin
                if (relax)
                begin
                    dist_we           = 1'b1;
                    valid_next[j_reg] = 1'b1;
                    path_we           = record_reg;
                    if (!mark_reg[j_reg])
                    begin
                        mark_next[j_reg] = 1'b1;
                        q_we             = 1'b1;
                        tail_next  = (tail_reg == LAST_SLOT) ? '0 : IDX_BITS'(tail_reg + 1'b1);
                        count_next = CNT_BITS'(count_reg + 1'b1);
                    end
                end
                j_next = IDX_BITS'(j_reg + 1'b1);
                if (j_reg == last_idx)
                begin
                    state_next = SS_POP;
                end
            end
            SS_DONE:
            begin
                state_next = SS_IDLE;
            end
            default:
            begin
                state_next = SS_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/most_vital_edge_shortest_path.sv
// top level: edge loading, path walk, result register and clearing pass
//
// Input channel s_axis: one undirected edge per item (node_a, node_b, weight),
// tlast marks the last edge of a graph. Edges load one per cycle. An edge with
// an endpoint of 0 or above MAX_VERTICES is not stored.
// Output channel m_axis: one item per graph, issued after the last edge.
// cfg_we/cfg_wdata set vertex_count (the target vertex) between graphs.
// After the last edge the block runs one search from vertex 1 and one more
// for each edge on the found path, so latency is data dependent: each queue
// pop of a search is followed by a neighbor scan over vertex_count vertices
// through the single read port of the distance memory and of the edge memory.
// The path has at most vertex_count - 1 edges.
// After the result is in the output register the edge memory is cleared, one
// entry per cycle over the whole address space (4096 entries at the default);
// the same pass runs after reset. No item is taken during the pass or the
// searches. A stalled receiver holds the result; the block waits before
// writing the next one until the register is free.
module most_vital_edge_shortest_path #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mvesp_pkg::COUNT_BITS-1:0]    cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // node_a [6:0], node_b [13:7], weight [29:14], zero [31:30]
    input  logic [mvesp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // base_distance [21:0], longest_detour [43:22], target_unreachable [44],
    // deletion_disconnects [45], zero [47:46]
    output logic [mvesp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import mvesp_pkg::*;

    `include "most_vital_edge_shortest_path_macros.svh"

    localparam int IDX_BITS  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam int DIST_BITS = WEIGHT_BITS + $clog2(MAX_VERTICES);
    localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);

    top_state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] vcount_reg;
    logic [ADDR_BITS-1:0]  clr_reg, clr_next;
    logic [IDX_BITS-1:0]   v_reg, v_next, h_reg, h_next;
    logic [CNT_BITS-1:0]   steps_reg, steps_next;
    logic [DIST_BITS-1:0]  base_reg, base_next, best_reg, best_next;
    logic unr_reg, unr_next, disc_reg, disc_next;
    logic out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [NODE_BITS-1:0]  node_a, node_b;
    logic [WIN_BITS-1:0]   weight;
    logic [IDX_BITS-1:0]   a_idx, b_idx, last_idx;
    logic [31:0]           n_val;
    logic                  in_accept, edge_ok;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
    logic [WEIGHT_BITS:0]  ram_wdata, ram_rdata;
    search_cmd_t           cmd;
    search_status_t        status;
    logic [DIST_BITS-1:0]  target_dist;
    logic [IDX_BITS-1:0]   path_data;

    // input fields
    assign node_a    = s_axis_tdata[NODE_BITS-1:0];
    assign node_b    = s_axis_tdata[2*NODE_BITS-1:NODE_BITS];
    assign weight    = s_axis_tdata[2*NODE_BITS+WIN_BITS-1:2*NODE_BITS];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign edge_ok   = (node_a != '0) && (node_b != '0)
                    && (32'(node_a) <= MAX_VERTICES) && (32'(node_b) <= MAX_VERTICES);
    assign a_idx     = IDX_BITS'(32'(node_a) - 32'd1);
    assign b_idx     = IDX_BITS'(32'(node_b) - 32'd1);

    // vertex count clamped to the supported range
    assign n_val    = (vcount_reg == '0) ? 32'd1
                    : ((32'(vcount_reg) > MAX_VERTICES) ? MAX_VERTICES : 32'(vcount_reg));
    assign last_idx = IDX_BITS'(n_val - 32'd1);

    // edge memory write side: clearing pass or edge load, stored once per pair
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (in_accept && edge_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = (a_idx < b_idx) ? {a_idx, b_idx} : {b_idx, a_idx};
            ram_wdata = {1'b1, WEIGHT_BITS'(weight)};
        end
    end

    mvesp_edge_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (WEIGHT_BITS + 1)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mvesp_search #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .IDX_BITS     (IDX_BITS),
        .DIST_BITS    (DIST_BITS)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .block_a     (path_data),
        .block_b     (v_reg),
        .last_idx    (last_idx),
        .status      (status),
        .target_dist (target_dist),
        .edge_raddr  (ram_raddr),
        .edge_rdata  (ram_rdata),
        .path_addr   (v_reg),
        .path_data   (path_data)
    );

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        h_reg        <= h_next;
        steps_reg    <= steps_next;
        base_reg     <= base_next;
        best_reg     <= best_next;
        unr_reg      <= unr_next;
        disc_reg     <= disc_next;
        out_data_reg <= out_data_next;
    end

    // job sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        v_next         = v_reg;
        h_next         = h_reg;
        steps_next     = steps_reg;
        base_next      = base_reg;
        best_next      = best_reg;
        unr_next       = unr_reg;
        disc_next      = disc_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = ADDR_BITS'(clr_reg + 1'b1);
                if (clr_reg == '1)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (in_accept && s_axis_tlast)
                begin
                    cmd.start  = 1'b1;
                    cmd.record = 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (status.done)
                begin
                    best_next  = '0;
                    disc_next  = 1'b0;
                    v_next     = last_idx;
                    steps_next = '0;
                    if (status.reached)
                    begin
                        unr_next   = 1'b0;
                        base_next  = target_dist;
                        state_next = ST_WALK_RD;
                    end
                    else
                    begin
                        unr_next   = 1'b1;
                        base_next  = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WALK_RD:
            begin
                // predecessor of v is read here; stop at the source or once the step count reaches the vertex count
                if ((v_reg == '0) || (32'(steps_reg) >= n_val))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_WALK_WAIT;
                end
            end
            ST_WALK_WAIT:
            begin
                cmd.start    = 1'b1;
                cmd.blocking = 1'b1;
                h_next       = path_data;
                state_next   = ST_BLOCK_WAIT;
            end
            ST_BLOCK_WAIT:
            begin
                if (status.done)
                begin
                    if (status.reached)
                    begin
                        if (target_dist > best_reg)
                        begin
                            best_next = target_dist;
                        end
                    end
                    else
                    begin
                        disc_next = 1'b1;
                    end
                    v_next     = h_reg;
                    steps_next = CNT_BITS'(steps_reg + 1'b1);
                    state_next = ST_WALK_RD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, disc_reg, unr_reg,
                                      OUT_BITS'(best_reg), OUT_BITS'(base_reg)};
                    clr_next       = '0;
                    state_next     = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // checks on the sequencing between the top level and the search engine
    `MVESP_ASSERT_IMPL(a_start_idle, cmd.start, !status.busy, "search started while busy")
    `MVESP_ASSERT_IMPL(a_done_waited, status.done,
        (state_reg == ST_BASE) || (state_reg == ST_BLOCK_WAIT), "unexpected search end")
    `MVESP_ASSERT_IMPL(a_unreach_zero, m_axis_tvalid && m_axis_tdata[44],
        m_axis_tdata[43:0] == '0 && !m_axis_tdata[45], "unreachable result not zeroed")
    `MVESP_ASSERT(a_no_load_busy, !(s_axis_tready && status.busy), "load during search")
endmodule
